@@ src/tnpd_pkg.sv @@
// ----------------------------------------------------------------------------
// tnpd_pkg
// Shared types and constants of the two-nearest-colour palette ditherer.
// ----------------------------------------------------------------------------
package tnpd_pkg;

    localparam int MaxColors     = 256;
    localparam int MaxMapEntries = 256;
    localparam int CoordBits     = 12;
    localparam int ColorIdxBits  = $clog2(MaxColors);
    localparam int MapIdxBits    = $clog2(MaxMapEntries);
    localparam int SizeBits      = ColorIdxBits + 1;
    localparam int DistBits      = 18;
    localparam int KeyBits       = 28;
    localparam int TsumBits      = 10;
    localparam logic [TsumBits-1:0] ThreshFull = 10'd765;

    localparam logic [1:0] OP_DITHER = 2'd0;
    localparam logic [1:0] OP_LOAD_PAL = 2'd1;
    localparam logic [1:0] OP_LOAD_MAP = 2'd2;

    localparam logic [1:0] CFG_PALETTE_SIZE = 2'd0;
    localparam logic [1:0] CFG_MAP_WIDTH    = 2'd1;
    localparam logic [1:0] CFG_MAP_HEIGHT   = 2'd2;

    typedef struct packed {
        logic load_pal;
        logic load_map;
        logic start;
        logic scan;
        logic hsv_step;
        logic decide_rd;
        logic decide;
        logic out_rd;
    } tnpd_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic hsv_done;
    } tnpd_status_t;

endpackage

@@ src/two_nearest_palette_dither.sv @@
// ----------------------------------------------------------------------------
// two_nearest_palette_dither
// Ordered dither between the two palette colours nearest to each pixel.
// ----------------------------------------------------------------------------
// A palette load divides out its HSV key one quotient bit a cycle, and no
// new request is taken before the division is done; a threshold load is
// written to the threshold store when it is accepted. A dither request scans
// one palette entry a cycle through the palette read port while the tile
// coordinates are reduced by up to 255 tile steps a cycle. The scan ends once
// every entry has been compared and both coordinates lie inside the tile.
// The result then passes the threshold-read, decide and result-read states
// before it is shown, and the next request is taken once the result has been
// accepted.
module two_nearest_palette_dither (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[1:0], entry_index[9:2], red[17:10], green[25:18], blue[33:26],
    // pixel_x[45:34], pixel_y[57:46]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16], chosen_index[31:24]
    output logic [31:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);
    import tnpd_pkg::*;

    tnpd_cmd_t    cmd;
    tnpd_status_t status;
    logic [8:0]   psize_reg;
    logic [4:0]   mw_reg, mh_reg;
    logic [31:0]  res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            psize_reg <= 9'd1;
            mw_reg    <= 5'd8;
            mh_reg    <= 5'd8;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PALETTE_SIZE: psize_reg <= cfg_data;
                CFG_MAP_WIDTH:    mw_reg <= cfg_data[4:0];
                CFG_MAP_HEIGHT:   mh_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    tnpd_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .op(s_tdata[1:0]),
        .m_tvalid, .m_tready, .cmd, .status
    );

    tnpd_datapath u_dp (
        .aclk, .aresetn, .cmd, .status,
        .in_idx(s_tdata[9:2]), .in_r(s_tdata[17:10]), .in_g(s_tdata[25:18]),
        .in_b(s_tdata[33:26]), .in_x(s_tdata[45:34]), .in_y(s_tdata[57:46]),
        .palette_size(psize_reg), .map_width(mw_reg), .map_height(mh_reg),
        .result(res)
    );

    assign m_tdata = {res[7:0], res[15:8], res[23:16], res[31:24]};

endmodule

@@ src/tnpd_datapath.sv @@
// ----------------------------------------------------------------------------
// tnpd_datapath
// Palette and threshold stores, distance scan, HSV key divider and decision.
// ----------------------------------------------------------------------------
module tnpd_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tnpd_pkg::tnpd_cmd_t    cmd,
    output tnpd_pkg::tnpd_status_t status,
    input  logic [7:0]             in_idx,
    input  logic [7:0]             in_r,
    input  logic [7:0]             in_g,
    input  logic [7:0]             in_b,
    input  logic [11:0]            in_x,
    input  logic [11:0]            in_y,
    input  logic [8:0]             palette_size,
    input  logic [4:0]             map_width,
    input  logic [4:0]             map_height,
    output logic [31:0]            result
);
    import tnpd_pkg::*;

    logic [23:0]         pal_mem [MaxColors];
    logic [KeyBits-1:0]  key_mem [MaxColors];
    logic [TsumBits-1:0] map_mem [MaxMapEntries];

    logic [7:0] r_reg, g_reg, b_reg;
    logic [ColorIdxBits-1:0] idx_reg;
    logic [SizeBits-1:0] n_reg;
    logic [SizeBits-1:0] k_reg;
    logic [SizeBits-1:0] kd_reg;
    logic                rd_vld_reg;
    logic [23:0]         pal_rd_reg;
    logic [ColorIdxBits-1:0] i1_reg, i2_reg;
    logic [DistBits-1:0] d1_reg, d2_reg;
    logic                v1_reg, v2_reg;
    logic [MapIdxBits-1:0] addr_reg;
    logic [TsumBits-1:0] tsum_reg;
    logic [KeyBits-1:0]  k1_reg, k2_reg;
    logic [ColorIdxBits-1:0] chosen_reg;

    // HSV key unit: two restoring dividers, one quotient bit per cycle.
    logic [7:0]  v_reg, d_reg;
    logic [16:0] sn_reg, hn_reg;
    logic [8:0]  sq_reg, hq_reg;
    logic [10:0] hbase_reg;
    logic        hneg_reg;
    logic [3:0]  dcnt_reg;
    logic [7:0]  mx, mn, hnum;
    logic [10:0] hbase;
    logic        hneg;

    always_comb begin
        mx = in_r;
        if (in_g > mx) mx = in_g;
        if (in_b > mx) mx = in_b;
        mn = in_r;
        if (in_g < mn) mn = in_g;
        if (in_b < mn) mn = in_b;
        if (mx == in_r) begin
            hbase = in_g >= in_b ? 11'd0 : 11'd1536;
            hneg  = in_g < in_b;
            hnum  = in_g >= in_b ? in_g - in_b : in_b - in_g;
        end else if (mx == in_g) begin
            hbase = 11'd512;
            hneg  = in_b < in_r;
            hnum  = in_b >= in_r ? in_b - in_r : in_r - in_b;
        end else begin
            hbase = 11'd1024;
            hneg  = in_r < in_g;
            hnum  = in_r >= in_g ? in_r - in_g : in_g - in_r;
        end
    end

    logic [16:0] s_try, h_try;
    logic        s_ge, h_ge;
    always_comb begin
        s_try = {sn_reg[15:0], 1'b0};
        h_try = {hn_reg[15:0], 1'b0};
        s_ge  = s_try[16:8] >= {1'b0, v_reg};
        h_ge  = h_try[16:8] >= {1'b0, d_reg};
    end

    assign status.hsv_done = dcnt_reg == 4'd0;

    function automatic logic [8:0] sq_h(input logic [8:0] q, input logic b);
        sq_h = {q[7:0], b};
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= 4'd0;
        end else if (cmd.load_pal) begin
            v_reg     <= mx;
            d_reg     <= mx - mn;
            sn_reg    <= {2'b0, mx - mn, 7'd0};
            hn_reg    <= {2'b0, hnum, 7'd0};
            sq_reg    <= 9'd0;
            hq_reg    <= 9'd0;
            hbase_reg <= hbase;
            hneg_reg  <= hneg;
            idx_reg   <= in_idx;
            pal_mem[in_idx] <= {in_r, in_g, in_b};
            dcnt_reg  <= 4'd9;
        end else if (cmd.hsv_step && dcnt_reg != 4'd0) begin
            // Remainder kept in the top bits; quotient shifted in from the bottom.
            sn_reg <= s_ge ? {s_try[16:8] - {1'b0, v_reg}, s_try[7:0]} : s_try;
            hn_reg <= h_ge ? {h_try[16:8] - {1'b0, d_reg}, h_try[7:0]} : h_try;
            sq_reg <= {sq_reg[7:0], s_ge};
            hq_reg <= {hq_reg[7:0], h_ge};
            dcnt_reg <= dcnt_reg - 4'd1;
            if (dcnt_reg == 4'd1) begin
                key_mem[idx_reg] <= {v_reg,
                    (v_reg == 8'd0) ? 9'd0 : {sq_reg[7:0], s_ge},
                    (d_reg == 8'd0) ? 11'd0 :
                    (hneg_reg ? hbase_reg - {2'b0, sq_h(hq_reg, h_ge)}
                              : hbase_reg + {2'b0, sq_h(hq_reg, h_ge)})};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_map) map_mem[in_idx] <= TsumBits'(in_r) + TsumBits'(in_g) + TsumBits'(in_b);
    end

    // Tile address: each scan cycle takes up to 255 tile widths off x and tile
    // heights off y, and the scan does not end before both lie inside the tile.
    logic [11:0] xm_reg, ym_reg;
    logic [4:0]  w_c, h_c;
    assign w_c = (map_width == 5'd0) ? 5'd1 : (map_width > 5'd16 ? 5'd16 : map_width);
    assign h_c = (map_height == 5'd0) ? 5'd1 : (map_height > 5'd16 ? 5'd16 : map_height);

    logic [11:0] x_sh, y_sh;
    always_comb begin
        x_sh = xm_reg;
        y_sh = ym_reg;
        for (int j = 3; j >= 0; j--) begin
            if (x_sh >= (12'(w_c) << (2 * j + 1))) x_sh = x_sh - (12'(w_c) << (2 * j + 1));
            if (x_sh >= (12'(w_c) << (2 * j))) x_sh = x_sh - (12'(w_c) << (2 * j));
            if (y_sh >= (12'(h_c) << (2 * j + 1))) y_sh = y_sh - (12'(h_c) << (2 * j + 1));
            if (y_sh >= (12'(h_c) << (2 * j))) y_sh = y_sh - (12'(h_c) << (2 * j));
        end
    end

    logic [7:0] dr, dg, db;
    logic [DistBits-1:0] dist_sum;
    always_comb begin
        dr = r_reg > pal_rd_reg[23:16] ? r_reg - pal_rd_reg[23:16] : pal_rd_reg[23:16] - r_reg;
        dg = g_reg > pal_rd_reg[15:8] ? g_reg - pal_rd_reg[15:8] : pal_rd_reg[15:8] - g_reg;
        db = b_reg > pal_rd_reg[7:0] ? b_reg - pal_rd_reg[7:0] : pal_rd_reg[7:0] - b_reg;
        dist_sum = DistBits'(dr * dr) + DistBits'(dg * dg) + DistBits'(db * db);
    end

    assign status.scan_last = !rd_vld_reg && (k_reg >= n_reg) &&
                              (xm_reg < 12'(w_c)) && (ym_reg < 12'(h_c));

    logic [SizeBits-1:0] n_c;
    assign n_c = (palette_size == 9'd0) ? 9'd1 :
                 (palette_size > 9'(MaxColors) ? 9'(MaxColors) : palette_size);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
            k_reg      <= '0;
            n_reg      <= '0;
        end else if (cmd.start) begin
            r_reg  <= in_r;
            g_reg  <= in_g;
            b_reg  <= in_b;
            xm_reg <= in_x;
            ym_reg <= in_y;
            n_reg  <= n_c;
            k_reg  <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
        end else if (cmd.scan) begin
            xm_reg <= x_sh;
            ym_reg <= y_sh;
            rd_vld_reg <= k_reg < n_reg;
            if (k_reg < n_reg) begin
                pal_rd_reg <= pal_mem[k_reg[ColorIdxBits-1:0]];
                kd_reg     <= k_reg;
                k_reg      <= k_reg + 1'b1;
            end
            if (rd_vld_reg) begin
                if (!v1_reg || dist_sum < d1_reg) begin
                    i2_reg <= i1_reg; d2_reg <= d1_reg; v2_reg <= v1_reg;
                    i1_reg <= kd_reg[ColorIdxBits-1:0]; d1_reg <= dist_sum; v1_reg <= 1'b1;
                end else if (!v2_reg || dist_sum < d2_reg) begin
                    i2_reg <= kd_reg[ColorIdxBits-1:0]; d2_reg <= dist_sum; v2_reg <= 1'b1;
                end
            end
        end
    end

    logic [11:0] addr_full;
    assign addr_full = xm_reg + 12'(w_c) * ym_reg[4:0];

    always_ff @(posedge aclk) begin
        if (cmd.decide_rd) begin
            tsum_reg <= map_mem[addr_full[MapIdxBits-1:0]];
            k1_reg   <= key_mem[i1_reg];
            k2_reg   <= key_mem[i2_reg];
        end
    end

    logic                    swap;
    logic [DistBits-1:0]     df, ds;
    logic [ColorIdxBits-1:0] if_, is_;
    logic [29:0]             lhs, rhs;
    always_comb begin
        swap = k1_reg > k2_reg;
        df   = swap ? d2_reg : d1_reg;
        ds   = swap ? d1_reg : d2_reg;
        if_  = swap ? i2_reg : i1_reg;
        is_  = swap ? i1_reg : i2_reg;
        lhs  = 30'(ThreshFull) * 30'(df);
        rhs  = 30'(tsum_reg) * (30'(df) + 30'(ds));
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            if (!v2_reg) chosen_reg <= i1_reg;
            else chosen_reg <= (lhs < rhs) ? if_ : is_;
        end
        if (cmd.out_rd) result <= {pal_mem[chosen_reg], chosen_reg};
    end

endmodule

@@ src/tnpd_ctrl.sv @@
// ----------------------------------------------------------------------------
// tnpd_ctrl
// Sequencer: accepts requests, runs the scan and hands the result out.
// ----------------------------------------------------------------------------
module tnpd_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [1:0]             op,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output tnpd_pkg::tnpd_cmd_t    cmd,
    input  tnpd_pkg::tnpd_status_t status
);
    import tnpd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_HSV, ST_SCAN, ST_DRD, ST_DEC, ST_ORD, ST_OUT
    } state_t;

    state_t state_reg;
    logic   acc;

    assign s_tready = state_reg == ST_IDLE ||
                      (state_reg == ST_HSV && status.hsv_done);
    assign acc      = s_tvalid && s_tready;
    assign m_tvalid = state_reg == ST_OUT;

    always_comb begin
        cmd           = '0;
        cmd.load_pal  = acc && op == OP_LOAD_PAL;
        cmd.load_map  = acc && op == OP_LOAD_MAP;
        cmd.start     = acc && op == OP_DITHER;
        cmd.hsv_step  = state_reg == ST_HSV;
        cmd.scan      = state_reg == ST_SCAN;
        cmd.decide_rd = state_reg == ST_DRD;
        cmd.decide    = state_reg == ST_DEC;
        cmd.out_rd    = state_reg == ST_ORD;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE, ST_HSV: begin
                    if (acc) begin
                        priority case (op)
                            OP_LOAD_PAL: state_reg <= ST_HSV;
                            OP_DITHER:   state_reg <= ST_SCAN;
                            default:     state_reg <= ST_IDLE;
                        endcase
                    end else if (state_reg == ST_HSV && status.hsv_done) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SCAN: if (status.scan_last) state_reg <= ST_DRD;
                ST_DRD:  state_reg <= ST_DEC;
                ST_DEC:  state_reg <= ST_ORD;
                ST_ORD:  state_reg <= ST_OUT;
                ST_OUT:  if (m_tready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ src/tnpd_checker.sv @@
// ----------------------------------------------------------------------------
// tnpd_checker
// Port-level checks on the ditherer's handshakes.
// ----------------------------------------------------------------------------
module tnpd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("request taken while result waits");
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid) else $error("result too early");
endmodule

bind two_nearest_palette_dither tnpd_checker u_chk (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
